// File: rtl/lrpf_pkg.sv
package lrpf_pkg;

  localparam int PANEL_WIDTH  = 128;
  localparam int PANEL_HEIGHT = 64;
  localparam int STORE_DEPTH  = 1024;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);
  localparam int IDX_W        = 15;

  typedef enum logic [1:0] {
    ACT_DRAW  = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  typedef logic signed [8:0]  pos_t;
  typedef logic signed [9:0]  coord_t;
  typedef logic signed [10:0] err_t;
  typedef logic [8:0]         dist_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [IDX_W-1:0]   idx_t;

  typedef struct packed {
    logic capture;
    logic setup1;
    logic setup2;
    logic px_rd;
    logic px_wr;
    logic clr_en;
    logic rd_en;
    logic load_result;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic clr_last;
  } sts_t;

endpackage

// File: rtl/line_raster_to_page_framebuffer.sv
// Channel   Direction  Handshake            Fields
// input     in         in_valid / in_stall  action, start_col, start_row, end_col, end_row,
//                                           ink, byte_addr
// result    out        out_valid/out_stall  read_byte, done_action
//
// From acceptance to the result register, a draw visits N+1 pixels, where N is the
// major-axis span (up to 511), and each pixel is a read then a write of the store.
// A clear writes one store byte per cycle over the whole store; a read does one store read.
// After reset a clearing pass over the whole store runs with in_stall high.
// One item is in work at a time; a finished result waits in its register while the next
// item is accepted, and the next result is held back only while that register is stalled.
module line_raster_to_page_framebuffer (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        action,
  input  logic signed [8:0] start_col,
  input  logic signed [8:0] start_row,
  input  logic signed [8:0] end_col,
  input  logic signed [8:0] end_row,
  input  logic              ink,
  input  logic [9:0]        byte_addr,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        read_byte,
  output logic [1:0]        done_action
);

  lrpf_pkg::cmd_t cmd;
  lrpf_pkg::sts_t sts;

  lrpf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .action    (action),
    .out_stall (out_stall),
    .sts       (sts),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  lrpf_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .action      (action),
    .start_col   (start_col),
    .start_row   (start_row),
    .end_col     (end_col),
    .end_row     (end_row),
    .ink         (ink),
    .byte_addr   (byte_addr),
    .sts         (sts),
    .read_byte   (read_byte),
    .done_action (done_action)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted but block not busy afterwards");

  a_zero_unless_read: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (done_action != lrpf_pkg::ACT_READ)) |-> (read_byte == 8'h00))
    else $error("nonzero read_byte on a non-read result");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without work in progress");

endmodule

// File: rtl/lrpf_ctrl.sv
module lrpf_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [1:0]      action,
  input  logic            out_stall,
  input  lrpf_pkg::sts_t  sts,
  output logic            in_stall,
  output logic            out_valid,
  output lrpf_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_SETUP1,
    S_SETUP2,
    S_PX_RD,
    S_PX_WR,
    S_CLR,
    S_RD,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_INIT: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          unique case (lrpf_pkg::action_t'(action))
            lrpf_pkg::ACT_DRAW:  state_next = S_SETUP1;
            lrpf_pkg::ACT_CLEAR: state_next = S_CLR;
            lrpf_pkg::ACT_READ:  state_next = S_RD;
            default:             state_next = S_DONE;
          endcase
        end
      end
      S_SETUP1: begin
        cmd.setup1 = 1'b1;
        state_next = S_SETUP2;
      end
      S_SETUP2: begin
        cmd.setup2 = 1'b1;
        state_next = S_PX_RD;
      end
      S_PX_RD: begin
        cmd.px_rd = 1'b1;
        cmd.rd_en = 1'b1;
        state_next = S_PX_WR;
      end
      S_PX_WR: begin
        cmd.px_wr = 1'b1;
        state_next = sts.cnt_zero ? S_DONE : S_PX_RD;
      end
      S_CLR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) begin
          state_next = S_DONE;
        end
      end
      S_RD: begin
        cmd.rd_en = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.load_result = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_result) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/lrpf_dp.sv
module lrpf_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  lrpf_pkg::cmd_t        cmd,
  input  logic [1:0]            action,
  input  logic signed [8:0]     start_col,
  input  logic signed [8:0]     start_row,
  input  logic signed [8:0]     end_col,
  input  logic signed [8:0]     end_row,
  input  logic                  ink,
  input  logic [9:0]            byte_addr,
  output lrpf_pkg::sts_t        sts,
  output logic [7:0]            read_byte,
  output logic [1:0]            done_action
);

  logic [7:0] mem [lrpf_pkg::STORE_DEPTH];
  logic [7:0] rdata;

  logic [1:0]          act;
  logic                ink_r;
  lrpf_pkg::pos_t      c0, r0, c1, r1;
  lrpf_pkg::addr_t     rd_addr_r;
  logic                steep;
  lrpf_pkg::pos_t      ma0, mi0, ma1, mi1;
  lrpf_pkg::coord_t    maj, mnr;
  lrpf_pkg::err_t      err;
  lrpf_pkg::dist_t     dmaj, dmin, cnt;
  logic                dir_up;
  lrpf_pkg::addr_t     pix_addr;
  logic [2:0]          pix_bit;
  logic                pix_ok;
  lrpf_pkg::addr_t     clr_cnt;

  lrpf_pkg::coord_t    dc, dr, adc, adr;
  logic                steep_c;
  lrpf_pkg::pos_t      a0, b0, a1, b1;
  lrpf_pkg::coord_t    dmaj_c, dmin_s, dmin_c;
  lrpf_pkg::coord_t    col, row;
  lrpf_pkg::idx_t      idx;
  logic                ok_c;
  lrpf_pkg::err_t      err_dec;
  logic                wr_en;
  lrpf_pkg::addr_t     wr_addr;
  logic [7:0]          wr_data;
  lrpf_pkg::addr_t     rd_addr;
  logic [7:0]          mask;

  always_comb begin
    dc = lrpf_pkg::coord_t'(c1) - lrpf_pkg::coord_t'(c0);
    dr = lrpf_pkg::coord_t'(r1) - lrpf_pkg::coord_t'(r0);
    adc = dc[9] ? -dc : dc;
    adr = dr[9] ? -dr : dr;
    steep_c = adr > adc;
    a0 = steep_c ? r0 : c0;
    b0 = steep_c ? c0 : r0;
    a1 = steep_c ? r1 : c1;
    b1 = steep_c ? c1 : r1;
  end

  always_comb begin
    dmaj_c = lrpf_pkg::coord_t'(ma1) - lrpf_pkg::coord_t'(ma0);
    dmin_s = lrpf_pkg::coord_t'(mi1) - lrpf_pkg::coord_t'(mi0);
    dmin_c = dmin_s[9] ? -dmin_s : dmin_s;
  end

  always_comb begin
    col = steep ? mnr : maj;
    row = steep ? maj : mnr;
    idx = lrpf_pkg::idx_t'(col[8:0])
        + lrpf_pkg::idx_t'(row[8:3]) * lrpf_pkg::idx_t'(lrpf_pkg::PANEL_WIDTH);
    ok_c = (col >= 0) && (col < lrpf_pkg::PANEL_WIDTH)
        && (row >= 0) && (row < lrpf_pkg::PANEL_HEIGHT)
        && (idx < lrpf_pkg::idx_t'(lrpf_pkg::STORE_DEPTH));
    err_dec = err - lrpf_pkg::err_t'({2'b00, dmin});
  end

  always_comb begin
    mask = 8'h01 << pix_bit;
    rd_addr = cmd.px_rd ? idx[lrpf_pkg::ADDR_W-1:0] : rd_addr_r;
    wr_en = cmd.clr_en || (cmd.px_wr && pix_ok);
    wr_addr = cmd.clr_en ? clr_cnt : pix_addr;
    wr_data = cmd.clr_en ? 8'h00 : (ink_r ? (rdata | mask) : (rdata & ~mask));
  end

  assign sts.cnt_zero = (cnt == '0);
  assign sts.clr_last = (clr_cnt == '1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_en) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act       <= action;
      ink_r     <= ink;
      c0        <= start_col;
      r0        <= start_row;
      c1        <= end_col;
      r1        <= end_row;
      rd_addr_r <= byte_addr;
    end
    if (cmd.setup1) begin
      steep <= steep_c;
      if (a0 > a1) begin
        ma0 <= a1;
        mi0 <= b1;
        ma1 <= a0;
        mi1 <= b0;
      end else begin
        ma0 <= a0;
        mi0 <= b0;
        ma1 <= a1;
        mi1 <= b1;
      end
    end
    if (cmd.setup2) begin
      dmaj   <= dmaj_c[8:0];
      dmin   <= dmin_c[8:0];
      cnt    <= dmaj_c[8:0];
      err    <= lrpf_pkg::err_t'({2'b00, dmaj_c[8:1]});
      dir_up <= mi0 < mi1;
      maj    <= lrpf_pkg::coord_t'(ma0);
      mnr    <= lrpf_pkg::coord_t'(mi0);
    end
    if (cmd.px_rd) begin
      pix_addr <= idx[lrpf_pkg::ADDR_W-1:0];
      pix_bit  <= row[2:0];
      pix_ok   <= ok_c;
    end
    if (cmd.px_wr) begin
      maj <= maj + 10'sd1;
      cnt <= cnt - 1'b1;
      if (err_dec < 0) begin
        mnr <= dir_up ? mnr + 10'sd1 : mnr - 10'sd1;
        err <= err_dec + lrpf_pkg::err_t'({2'b00, dmaj});
      end else begin
        err <= err_dec;
      end
    end
    if (cmd.load_result) begin
      read_byte   <= (act == lrpf_pkg::ACT_READ) ? rdata : 8'h00;
      done_action <= act;
    end
  end

endmodule

// File: sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lrpf_pkg::*;

  typedef struct packed {
    action_t    act;
    pos_t       c0;
    pos_t       r0;
    pos_t       c1;
    pos_t       r1;
    logic       ink;
    addr_t      addr;
    logic       typed;
    logic [7:0] typed_byte;
  } fb_cmd_t;

  typedef struct packed {
    logic [7:0] rb;
    action_t    da;
  } fb_reply_t;

  localparam pos_t POS_MIN = 9'h100;
  localparam pos_t POS_MAX = 9'h0FF;
  localparam int   N_DIRECTED = 25;
  localparam int   N_RANDOM = 450;

  localparam fb_cmd_t DIRECTED [N_DIRECTED] = '{
    '{ACT_READ,  9'sd0,   9'sd0,   9'sd0,   9'sd0,   1'b0, 10'd0,    1'b1, 8'h00},
    '{ACT_READ,  9'sd77,  -9'sd3,  9'sd12,  9'sd1,   1'b1, 10'd1023, 1'b1, 8'h00},
    '{ACT_NOP,   9'sd10,  9'sd10,  9'sd90,  9'sd40,  1'b1, 10'd512,  1'b1, 8'h00},
    '{ACT_DRAW,  9'sd0,   9'sd0,   9'sd127, 9'sd0,   1'b1, 10'd0,    1'b1, 8'h00},
    '{ACT_READ,  9'sd0,   9'sd0,   9'sd0,   9'sd0,   1'b0, 10'd0,    1'b0, 8'h00},
    '{ACT_READ,  9'sd0,   9'sd0,   9'sd0,   9'sd0,   1'b0, 10'd127,  1'b0, 8'h00},
    '{ACT_DRAW,  9'sd5,   9'sd0,   9'sd5,   9'sd63,  1'b1, 10'd0,    1'b1, 8'h00},
    '{ACT_READ,  9'sd0,   9'sd0,   9'sd0,   9'sd0,   1'b0, 10'd901,  1'b0, 8'h00},
    '{ACT_DRAW,  9'sd100, 9'sd60,  9'sd90,  9'sd2,   1'b1, 10'd0,    1'b1, 8'h00},
    '{ACT_DRAW,  9'sd120, 9'sd50,  9'sd3,   9'sd10,  1'b1, 10'd0,    1'b1, 8'h00},
    '{ACT_DRAW,  9'sd64,  9'sd32,  9'sd64,  9'sd32,  1'b1, 10'd0,    1'b1, 8'h00},
    '{ACT_READ,  9'sd0,   9'sd0,   9'sd0,   9'sd0,   1'b0, 10'd576,  1'b0, 8'h00},
    '{ACT_DRAW,  POS_MIN, POS_MIN, POS_MAX, POS_MAX, 1'b1, 10'd0,    1'b1, 8'h00},
    '{ACT_DRAW,  POS_MAX, POS_MIN, POS_MIN, POS_MAX, 1'b1, 10'd0,    1'b1, 8'h00},
    '{ACT_DRAW,  POS_MIN, 9'sd100, -9'sd10, 9'sd200, 1'b1, 10'd0,    1'b1, 8'h00},
    '{ACT_DRAW,  9'sd127, 9'sd63,  9'sd128, 9'sd64,  1'b1, 10'd0,    1'b1, 8'h00},
    '{ACT_READ,  9'sd0,   9'sd0,   9'sd0,   9'sd0,   1'b0, 10'd1023, 1'b0, 8'h00},
    '{ACT_DRAW,  9'sd0,   9'sd0,   9'sd127, 9'sd0,   1'b0, 10'd0,    1'b1, 8'h00},
    '{ACT_READ,  9'sd0,   9'sd0,   9'sd0,   9'sd0,   1'b0, 10'd0,    1'b0, 8'h00},
    '{ACT_DRAW,  9'sd0,   -9'sd1,  9'sd0,   9'sd64,  1'b1, 10'd0,    1'b1, 8'h00},
    '{ACT_READ,  9'sd0,   9'sd0,   9'sd0,   9'sd0,   1'b0, 10'd0,    1'b0, 8'h00},
    '{ACT_CLEAR, 9'sd33,  -9'sd7,  POS_MAX, POS_MIN, 1'b1, 10'd700,  1'b1, 8'h00},
    '{ACT_READ,  9'sd0,   9'sd0,   9'sd0,   9'sd0,   1'b0, 10'd901,  1'b1, 8'h00},
    '{ACT_NOP,   -9'sd1,  -9'sd1,  -9'sd1,  -9'sd1,  1'b1, 10'd1023, 1'b1, 8'h00},
    '{ACT_READ,  POS_MIN, POS_MAX, POS_MIN, POS_MAX, 1'b1, 10'd1023, 1'b1, 8'h00}
  };

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        action;
  logic signed [8:0] start_col;
  logic signed [8:0] start_row;
  logic signed [8:0] end_col;
  logic signed [8:0] end_row;
  logic              ink;
  logic [9:0]        byte_addr;
  logic              out_valid;
  logic              out_stall;
  logic [7:0]        read_byte;
  logic [1:0]        done_action;

  logic [7:0] shadow_fb [STORE_DEPTH];
  int         recent_bytes [$];
  fb_reply_t  predicted_replies [$];
  int         fails = 0;
  logic       quiet = 1'b0;

  line_raster_to_page_framebuffer dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .start_col  (start_col),
    .start_row  (start_row),
    .end_col    (end_col),
    .end_row    (end_row),
    .ink        (ink),
    .byte_addr  (byte_addr),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_byte  (read_byte),
    .done_action(done_action)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int magnitude(input int v);
    return (v < 0) ? -v : v;
  endfunction

  task automatic paint_pixel(input int col, input int row, input logic on);
    int idx;
    if (col < 0 || col >= PANEL_WIDTH || row < 0 || row >= PANEL_HEIGHT) return;
    idx = col + (row / 8) * PANEL_WIDTH;
    if (idx >= STORE_DEPTH) return;
    if (on) shadow_fb[idx] = shadow_fb[idx] | (8'h01 << (row % 8));
    else shadow_fb[idx] = shadow_fb[idx] & ~(8'h01 << (row % 8));
    recent_bytes.push_back(idx);
    if (recent_bytes.size() > 64) void'(recent_bytes.pop_front());
  endtask

  task automatic trace_line(input int c0, input int r0, input int c1, input int r1,
                            input logic on);
    int   t;
    int   dmaj;
    int   dmin;
    int   err;
    int   step;
    logic steep;
    steep = magnitude(r1 - r0) > magnitude(c1 - c0);
    if (steep) begin
      t = c0; c0 = r0; r0 = t;
      t = c1; c1 = r1; r1 = t;
    end
    if (c0 > c1) begin
      t = c0; c0 = c1; c1 = t;
      t = r0; r0 = r1; r1 = t;
    end
    dmaj = c1 - c0;
    dmin = magnitude(r1 - r0);
    err = dmaj / 2;
    step = (r0 < r1) ? 1 : -1;
    for (; c0 <= c1; c0++) begin
      if (steep) paint_pixel(r0, c0, on);
      else paint_pixel(c0, r0, on);
      err -= dmin;
      if (err < 0) begin
        r0 += step;
        err += dmaj;
      end
    end
  endtask

  task automatic apply_fb_cmd(input fb_cmd_t c);
    fb_reply_t r;
    r.rb = 8'h00;
    r.da = c.act;
    case (c.act)
      ACT_DRAW: begin
        trace_line(int'(c.c0), int'(c.r0), int'(c.c1), int'(c.r1), c.ink);
      end
      ACT_CLEAR: begin
        foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;
      end
      ACT_READ: begin
        r.rb = shadow_fb[c.addr];
      end
      default: begin
      end
    endcase
    if (c.typed) r.rb = c.typed_byte;
    predicted_replies.push_back(r);
  endtask

  function automatic fb_cmd_t random_fb_cmd();
    fb_cmd_t c;
    int      pick;
    c.act = ACT_DRAW;
    c.c0 = pos_t'($urandom);
    c.r0 = pos_t'($urandom);
    c.c1 = pos_t'($urandom);
    c.r1 = pos_t'($urandom);
    c.ink = ($urandom_range(99) < 70);
    c.addr = addr_t'($urandom);
    c.typed = 1'b0;
    c.typed_byte = 8'h00;
    pick = $urandom_range(99);
    if (pick < 55) begin
      c.c0 = pos_t'($urandom_range(170) - 20);
      c.c1 = pos_t'($urandom_range(170) - 20);
      c.r0 = pos_t'($urandom_range(100) - 20);
      c.r1 = pos_t'($urandom_range(100) - 20);
    end else if (pick < 65) begin
      c.act = ACT_DRAW;
    end else if (pick < 92) begin
      c.act = ACT_READ;
      if (recent_bytes.size() > 0 && $urandom_range(99) < 70)
        c.addr = addr_t'(recent_bytes[$urandom_range(recent_bytes.size() - 1)]);
    end else if (pick < 96) begin
      c.act = ACT_CLEAR;
    end else begin
      c.act = ACT_NOP;
    end
    return c;
  endfunction

  task automatic send_fb_cmd(input fb_cmd_t c);
    if (!quiet && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 50) @(posedge clk);
    end
    in_valid  <= 1'b1;
    action    <= c.act;
    start_col <= c.c0;
    start_row <= c.r0;
    end_col   <= c.c1;
    end_row   <= c.r1;
    ink       <= c.ink;
    byte_addr <= c.addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_fb_cmd(c);
  endtask

  always @(posedge clk) begin
    out_stall <= (!rst && !quiet && $urandom_range(99) < 14);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (predicted_replies.size() == 0) begin
        $error("unexpected transaction: read_byte %0h, done_action %0d",
               read_byte, done_action);
        fails++;
      end else begin
        if (read_byte !== predicted_replies[0].rb) begin
          $error("read_byte: expected %0h, actual %0h", predicted_replies[0].rb, read_byte);
          fails++;
        end
        if (done_action !== predicted_replies[0].da) begin
          $error("done_action: expected %0d, actual %0d",
                 predicted_replies[0].da, done_action);
          fails++;
        end
        void'(predicted_replies.pop_front());
      end
    end
  end

  initial begin
    #30_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    action    <= ACT_NOP;
    start_col <= '0;
    start_row <= '0;
    end_col   <= '0;
    end_row   <= '0;
    ink       <= 1'b0;
    byte_addr <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (DIRECTED[i]) send_fb_cmd(DIRECTED[i]);
    for (int n = 0; n < N_RANDOM; n++) begin
      quiet = (n >= 200 && n < 300);
      send_fb_cmd(random_fb_cmd());
    end
    quiet = 1'b0;
    in_valid <= 1'b0;
    while (predicted_replies.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (fails == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
